/* hw/rtl/mmf_pkg.sv */
// shared types, constants and helper functions for the median-of-medians filter
`timescale 1ns / 1ps

package mmf_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;

   localparam int PixW  = 8;
   localparam int DimW  = 9;
   localparam int AddrW = $clog2(MAX_WIDTH);
   localparam int PosW  = 8;

   localparam logic [DimW-1:0] DimMin      = DimW'(3);
   localparam logic [DimW-1:0] WidthMax    = DimW'(MAX_WIDTH);
   localparam logic [DimW-1:0] HeightMax   = DimW'(MAX_HEIGHT);
   localparam logic [DimW-1:0] WidthReset  = DimW'(188);
   localparam logic [DimW-1:0] HeightReset = DimW'(120);

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } mmf_csr_addr_type;

   typedef struct packed {
      logic            mode;
      logic [PixW-1:0] pixel_in;
   } mmf_req_type;

   typedef struct packed {
      logic [PixW-1:0] pixel_out;
      logic [PosW-1:0] out_row;
      logic [PosW-1:0] out_col;
      logic            frame_done;
   } mmf_rsp_type;

   function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                 input logic [DimW-1:0] hi);
      logic [DimW-1:0] r;
      if (v < DimMin) r = DimMin;
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction

   function automatic logic [PixW-1:0] med3(input logic [PixW-1:0] a,
                                            input logic [PixW-1:0] b,
                                            input logic [PixW-1:0] c);
      logic [PixW-1:0] r;
      if ((b >= a && b <= c) || (b <= a && b >= c)) r = b;
      else if ((a >= b && a >= c) || (a <= b && a <= c)) r = c;
      else r = a;
      return r;
   endfunction

endpackage

/* hw/rtl/mmf_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module mmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/median_of_medians_3x3_filter_top.sv */
// top level of the 3x3 median-of-medians filter: line stores, window and result register
`timescale 1ns / 1ps
//
// 3x3 pseudo-median filter for an 8-bit raster pixel stream.
// req channel: one beat per pixel in raster order (mode 0), then width+1 flush
//   beats (mode 1) after the last pixel of the frame to drain the window.
// rsp channel: zero or one beat per request beat, carrying the filtered pixel,
//   its row and column and a frame_done flag on the frame's last pixel.
//   Border rows and columns pass through; inside pixels take the median of
//   the three row medians of their window.
// csr channel: index 0 writes frame_width, index 1 frame_height (clamped to
//   3..256); a write to either restarts the frame, other indexes are ignored.
//   csr_ready is always high.
// Output: a result is loaded into the result register by the request beat that
//   completes its window, i.e. one row plus one pixel after the pixel itself
//   arrived.
// Throughput: one beat per cycle while the result register is free or rsp_ready
//   is high; the line stores are read ahead of use at the next column address,
//   so each store sees one read and one write per cycle.
// Reset: counters go to row 0, column 0, the window clears and the sizes
//   return to 188 x 120; the line stores are not cleared and need no sweep.
// Stall: while a result waits and rsp_ready is low, req_ready is low.

module median_of_medians_3x3_filter_top
   import mmf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mmf_req_type       req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mmf_rsp_type       rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_addr,
   input  logic [DimW-1:0]   csr_wdata
);

   logic [DimW-1:0]  width_ff, width_in;
   logic [DimW-1:0]  height_ff, height_in;
   logic [DimW-1:0]  row_ff, row_in;
   logic [AddrW-1:0] col_ff, col_in;
   logic [PixW-1:0]  win_ff [3][3];
   logic [PixW-1:0]  win_in [3][3];
   logic             byp_ff, byp_in;
   logic [PixW-1:0]  byp_up_ff, byp_mid_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   mmf_rsp_type      rsp_ff, rsp_in;

   logic             accept;
   logic             csr_we;
   logic             csr_hit;
   logic [PixW-1:0]  up_rdata, mid_rdata;
   logic [PixW-1:0]  up_val, mid_val, pix_val;
   logic [DimW-1:0]  col_ext;
   logic [DimW-1:0]  oi, oj;
   logic             emit, done, border;
   logic [PixW-1:0]  med_a, med_b, med_d, result;
   logic [DimW-1:0]  col_inc, col_nx;
   logic [DimW-1:0]  row_nx;
   logic             wrap;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;
   assign csr_hit   = csr_we && (csr_addr == CSR_FRAME_WIDTH || csr_addr == CSR_FRAME_HEIGHT);

   // line stores, read ahead of use at the next column address
   mmf_ram #(.WIDTH(PixW), .DEPTH(MAX_WIDTH)) u_upper_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (mid_val),
      .rd_addr (col_in),
      .rd_data (up_rdata)
   );

   mmf_ram #(.WIDTH(PixW), .DEPTH(MAX_WIDTH)) u_middle_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (pix_val),
      .rd_addr (col_in),
      .rd_data (mid_rdata)
   );

   // same-address read during write returns the just-written data
   assign up_val  = byp_ff ? byp_up_ff  : up_rdata;
   assign mid_val = byp_ff ? byp_mid_ff : mid_rdata;
   assign pix_val = (row_ff < height_ff && !req_payload.mode) ? req_payload.pixel_in : '0;
   assign col_ext = DimW'(col_ff);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k][0] = win_ff[k][1];
         win_in[k][1] = win_ff[k][2];
      end
      win_in[0][2] = up_val;
      win_in[1][2] = mid_val;
      win_in[2][2] = pix_val;
   end

   always_comb begin
      if (col_ff != '0) begin
         oi   = row_ff - DimW'(1);
         oj   = col_ext - DimW'(1);
         emit = (row_ff >= DimW'(1));
      end else begin
         oi   = row_ff - DimW'(2);
         oj   = width_ff - DimW'(1);
         emit = (row_ff >= DimW'(2));
      end
      emit = emit && (oi < height_ff);
   end

   assign border = (oi == '0) || (oi == height_ff - DimW'(1)) ||
                   (oj == '0) || (oj == width_ff - DimW'(1));
   assign med_a  = med3(win_in[0][0], win_in[0][1], win_in[0][2]);
   assign med_b  = med3(win_in[1][0], win_in[1][1], win_in[1][2]);
   assign med_d  = med3(win_in[2][0], win_in[2][1], win_in[2][2]);
   // border pixel is the middle row's newest column before the shift
   assign result = border ? win_ff[1][2] : med3(med_a, med_b, med_d);
   assign done   = emit && (oi == height_ff - DimW'(1)) && (oj == width_ff - DimW'(1));

   assign col_inc = col_ext + DimW'(1);
   assign wrap    = (col_inc >= width_ff);
   always_comb begin
      col_nx = wrap ? '0 : col_inc;
      row_nx = wrap ? row_ff + DimW'(1) : row_ff;
      if (done || ({1'b0, row_nx} > ({1'b0, height_ff} + (DimW+1)'(1)))) begin
         col_nx = '0;
         row_nx = '0;
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_FRAME_WIDTH:  width_in  = clamp_dim(csr_wdata, WidthMax);
            CSR_FRAME_HEIGHT: height_in = clamp_dim(csr_wdata, HeightMax);
            default: ;
         endcase
      end
      if (csr_hit) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         row_in = row_nx;
         col_in = col_nx[AddrW-1:0];
      end
   end

   assign byp_in = accept && (col_in == col_ff);

   always_comb begin
      rsp_in.pixel_out  = result;
      rsp_in.out_row    = oi[PosW-1:0];
      rsp_in.out_col    = oj[PosW-1:0];
      rsp_in.frame_done = done;
      if (accept) rsp_valid_in = emit;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WidthReset;
         height_ff    <= HeightReset;
         row_ff       <= '0;
         col_ff       <= '0;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[k][j] <= '0;
            end
         end
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         byp_ff       <= byp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            win_ff <= win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      byp_up_ff  <= mid_val;
      byp_mid_ff <= pix_val;
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      DimW'(col_ff) < width_ff)
      else $error("column counter beyond frame width");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled with empty result register");

   a_done_last_col: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.frame_done) |->
         (rsp_ff.out_col == PosW'(width_ff - DimW'(1))))
      else $error("frame_done on a column other than the last");

   a_bypass_after_beat: assert property (@(posedge clock) disable iff (reset)
      byp_ff |-> $past(accept))
      else $error("store bypass without a preceding beat");

endmodule
